FILE: rtl/grt_pkg.sv
// package: word types, register indexes and widths of the refinement tagger
`timescale 1ns / 1ps
`default_nettype none
package grt_pkg;

    localparam int DEF_AXES  = 3;
    localparam int MAX_AXES  = 3;
    localparam int VAL_W     = 32;
    localparam int EXT_W     = 44;   // holds 100 * b and 100 * a exactly
    localparam int Q_W       = 32;   // quotient bits, unsigned Q16.16
    localparam int FRAC_W    = 16;

    localparam logic [0:0]  REG_THRESHOLD = 1'b0;
    localparam logic [0:0]  REG_FLOOR     = 1'b1;
    localparam logic [31:0] THRESHOLD_RST = 32'h0001_0000;
    localparam logic [31:0] FLOOR_RST     = 32'hFFFF_0000;
    localparam logic [31:0] CRIT_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] center_value;
        logic signed [31:0] x_minus;
        logic signed [31:0] x_plus;
        logic signed [31:0] y_minus;
        logic signed [31:0] y_plus;
        logic signed [31:0] z_minus;
        logic signed [31:0] z_plus;
        logic               already_tagged;
        logic               covered;
    } grt_in_t;

    typedef struct packed {
        logic        tag_out;
        logic [31:0] criterion;
    } grt_out_t;

    function automatic logic signed [EXT_W-1:0] times100(input logic signed [EXT_W-1:0] v);
        times100 = (v <<< 6) + (v <<< 5) + (v <<< 2);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/grt_lane.sv
// one axis lane: difference front end and a 32-step pipelined divider
`timescale 1ns / 1ps
`default_nettype none
module grt_lane (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic signed [31:0]  s0,
    input  wire logic signed [31:0]  s1,
    input  wire logic signed [31:0]  s2,
    input  wire logic signed [31:0]  floor_val,
    output logic [31:0]              crit
);
    import grt_pkg::*;

    logic signed [EXT_W-1:0] e0, e1, e2, a_val, d1, d0, b_val, f100;
    logic [EXT_W-1:0]        sum_abs, ab, num;
    logic                    floor_hit, zero_c, sat_c;

    always_comb
    begin
        e0      = EXT_W'(s0);
        e1      = EXT_W'(s1);
        e2      = EXT_W'(s2);
        a_val   = e2 - (e1 <<< 1) + e0;
        d1      = e2 - e1;
        d0      = e1 - e0;
        sum_abs = EXT_W'(d1[EXT_W-1] ? -d1 : d1) + EXT_W'(d0[EXT_W-1] ? -d0 : d0);
        b_val   = times100($signed(sum_abs)) + (e2 + (e1 <<< 1) + e0);
        ab      = b_val[EXT_W-1] ? EXT_W'(-b_val) : EXT_W'(b_val);
        num     = EXT_W'(times100(a_val[EXT_W-1] ? -a_val : a_val));
        f100    = times100(EXT_W'(floor_val));
        floor_hit = $signed({1'b0, ab}) <= $signed({f100[EXT_W-1], f100});
        zero_c  = floor_hit || (ab == '0 && num == '0);
        // quotient overflows 32 bits exactly when num / 2^16 >= ab
        sat_c   = !zero_c && (EXT_W'(num[EXT_W-1:FRAC_W]) >= ab);
    end

    // stage k holds the state after k quotient steps
    logic [EXT_W-1:0] rem_reg  [0:Q_W];
    logic [EXT_W-1:0] dvs_reg  [0:Q_W];
    logic [Q_W-1:0]   low_reg  [0:Q_W];
    logic [Q_W-1:0]   quo_reg  [0:Q_W];
    logic             zero_reg [0:Q_W];
    logic             sat_reg  [0:Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= EXT_W'(num[EXT_W-1:FRAC_W]);
            dvs_reg[0]  <= ab;
            low_reg[0]  <= {num[FRAC_W-1:0], {FRAC_W{1'b0}}};
            quo_reg[0]  <= '0;
            zero_reg[0] <= zero_c;
            sat_reg[0]  <= sat_c;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [EXT_W:0]   trial;
        logic             take;
        logic [EXT_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k], low_reg[k][Q_W-1]};
            take     = trial >= {1'b0, dvs_reg[k]};
            rem_next = take ? EXT_W'(trial - {1'b0, dvs_reg[k]}) : EXT_W'(trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                dvs_reg[k+1]  <= dvs_reg[k];
                low_reg[k+1]  <= {low_reg[k][Q_W-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][Q_W-2:0], take};
                zero_reg[k+1] <= zero_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
            end
        end
    end

    assign crit = zero_reg[Q_W] ? '0 : (sat_reg[Q_W] ? CRIT_MAX : quo_reg[Q_W]);

endmodule
`default_nettype wire

FILE: rtl/grt_merge.sv
// merge stage: largest lane criterion, threshold test, skipped cells
`timescale 1ns / 1ps
`default_nettype none
module grt_merge #(
    parameter int AXES = grt_pkg::DEF_AXES
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] crit [AXES],
    input  wire logic        skip,
    input  wire logic        was_tagged,
    input  wire logic [31:0] threshold,
    output grt_pkg::grt_out_t word
);
    import grt_pkg::*;

    logic [31:0] best;
    grt_out_t    word_next;
    grt_out_t    word_reg;

    always_comb
    begin
        best = '0;
        for (int i = 0; i < AXES; i++)
        begin
            if (crit[i] > best)
                best = crit[i];
        end
        if (skip)
        begin
            word_next.tag_out   = was_tagged;
            word_next.criterion = '0;
        end
        else
        begin
            word_next.tag_out   = best >= threshold;
            word_next.criterion = best;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign word = word_reg;

endmodule
`default_nettype wire

FILE: rtl/gradient_refinement_tagger_unit.sv
// top level: gradient refinement tagger with one lane per axis
`timescale 1ns / 1ps
`default_nettype none
// registers from input word to output word: front end, 32 divider steps, merge
// throughput: one word per unstalled cycle; set by the 32-stage restoring divider in each lane
// the whole pipeline advances while the output register is empty or being taken
// reset: rst_n asynchronous active low clears all valid bits, threshold to 1.0,
// denominator floor to -1.0; payload registers are not reset
module gradient_refinement_tagger_unit #(
    parameter int AXES = grt_pkg::DEF_AXES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire grt_pkg::grt_in_t  in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output grt_pkg::grt_out_t      out_word,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    import grt_pkg::*;

    localparam int DEPTH = Q_W + 1;   // lane register stages

    logic        en;
    logic [31:0] threshold_reg;
    logic [31:0] floor_reg;
    logic        vld_reg   [0:DEPTH-1];
    logic        skip_reg  [0:DEPTH-1];
    logic        tag_reg   [0:DEPTH-1];
    logic        out_valid_reg;
    logic [31:0] crit      [AXES];
    logic signed [31:0] lo_n [MAX_AXES];
    logic signed [31:0] hi_n [MAX_AXES];

    // stall everything only when a finished word is stuck at the output
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            floor_reg     <= FLOOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_FLOOR:     floor_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // valid line alongside the lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                vld_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    // skip flags ride along with the word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            skip_reg[0] <= in_word.covered || in_word.already_tagged;
            tag_reg[0]  <= in_word.already_tagged;
            for (int i = 1; i < DEPTH; i++)
            begin
                skip_reg[i] <= skip_reg[i-1];
                tag_reg[i]  <= tag_reg[i-1];
            end
        end
    end

    // neighbor pairs by axis
    always_comb
    begin
        lo_n[0] = in_word.x_minus;
        hi_n[0] = in_word.x_plus;
        lo_n[1] = in_word.y_minus;
        hi_n[1] = in_word.y_plus;
        lo_n[2] = in_word.z_minus;
        hi_n[2] = in_word.z_plus;
    end

    for (genvar d = 0; d < AXES; d++)
    begin : g_lane
        grt_lane u_lane (
            .clk       (clk),
            .en        (en),
            .s0        (lo_n[d]),
            .s1        (in_word.center_value),
            .s2        (hi_n[d]),
            .floor_val (floor_reg),
            .crit      (crit[d])
        );
    end

    grt_merge #(
        .AXES (AXES)
    ) u_merge (
        .clk        (clk),
        .en         (en),
        .crit       (crit),
        .skip       (skip_reg[DEPTH-1]),
        .was_tagged (tag_reg[DEPTH-1]),
        .threshold  (threshold_reg),
        .word       (out_word)
    );

endmodule
`default_nettype wire

FILE: rtl/grt_checker.sv
// port checker for the refinement tagger and its bind
`timescale 1ns / 1ps
`default_nettype none
module grt_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire grt_pkg::grt_out_t out_word
);
    import grt_pkg::*;

    // a stalled output word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word dropped or changed while stalled");

    // input side is open exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output register state");

    // a saturated criterion is never below any threshold
    a_sat_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.criterion == CRIT_MAX |-> out_word.tag_out)
        else $error("saturated criterion without tag");

endmodule

bind gradient_refinement_tagger_unit grt_checker u_grt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
`default_nettype wire

FILE: dv/tb_gradient_refinement_tagger_unit.sv
// testbench: gradient refinement tagger checked against a behavioral predictor
`timescale 1ns / 1ps
`default_nettype none

// scoreboard: predicts tag and criterion per accepted cell and checks each result word
class grt_tag_scoreboard;
    logic [31:0] threshold;
    logic [31:0] floor_q;
    grt_pkg::grt_out_t pending[$];
    int errors;

    function new();
        threshold = grt_pkg::THRESHOLD_RST;
        floor_q = grt_pkg::FLOOR_RST;
        errors = 0;
    endfunction

    // criterion of one axis, scaled by 100 so the 0.01 term stays exact
    function logic [31:0] axis_crit(longint s0, longint s1, longint s2);
        longint a;
        longint bb;
        longint d21;
        longint d10;
        longint fl;
        longint unsigned ab;
        longint unsigned num;
        longint unsigned q;
        a = s2 - 2 * s1 + s0;
        d21 = (s2 > s1) ? s2 - s1 : s1 - s2;
        d10 = (s1 > s0) ? s1 - s0 : s0 - s1;
        bb = 100 * (d21 + d10) + (s2 + 2 * s1 + s0);
        ab = (bb < 0) ? -bb : bb;
        fl = longint'($signed(floor_q)) * 100;
        if (longint'(ab) <= fl)
            return 32'd0;
        num = ((a < 0) ? -a : a) * 100;
        if (ab == 0)
            return (num == 0) ? 32'd0 : grt_pkg::CRIT_MAX;
        q = (num << 16) / ab;
        return (q > 64'hFFFF_FFFF) ? grt_pkg::CRIT_MAX : q[31:0];
    endfunction

    function void note_cell(grt_pkg::grt_in_t w);
        grt_pkg::grt_out_t r;
        logic [31:0] c;
        logic [31:0] best;
        best = 0;
        if (w.already_tagged || w.covered)
        begin
            r.tag_out = w.already_tagged;
            r.criterion = 0;
        end
        else
        begin
            c = axis_crit(w.x_minus, w.center_value, w.x_plus);
            if (c > best) best = c;
            c = axis_crit(w.y_minus, w.center_value, w.y_plus);
            if (c > best) best = c;
            c = axis_crit(w.z_minus, w.center_value, w.z_plus);
            if (c > best) best = c;
            r.tag_out = (best >= threshold);
            r.criterion = best;
        end
        pending = {pending, r};
    endfunction

    function void check_tag(grt_pkg::grt_out_t got);
        grt_pkg::grt_out_t exp_w;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected word tag=%0b crit=%h", $realtime, got.tag_out,
                     got.criterion);
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        if (got.tag_out !== exp_w.tag_out)
        begin
            $display("%0t: tag_out expected %0b actual %0b", $realtime, exp_w.tag_out,
                     got.tag_out);
            errors++;
        end
        if (got.criterion !== exp_w.criterion)
        begin
            $display("%0t: criterion expected %h actual %h", $realtime, exp_w.criterion,
                     got.criterion);
            errors++;
        end
    endfunction
endclass

module tb_gradient_refinement_tagger_unit;
    import grt_pkg::*;

    localparam int LATENCY = 34;
    localparam int WATCHDOG = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    grt_in_t in_word = '0;
    logic out_valid;
    logic out_ready = 0;
    grt_out_t out_word;
    logic cfg_we = 0;
    logic [0:0] cfg_index = REG_THRESHOLD;
    logic [31:0] cfg_data = 0;

    // idling percentages per phase, plus a forced long receiver hold-off
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit sink_hold = 0;
    int idle_cycles = 0;

    grt_tag_scoreboard sb;

    gradient_refinement_tagger_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // receiver side: random stall, result checked on the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_tag(out_word);
        out_ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog counts edges with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // offer one word and hold it until accepted; valid drops only in idle gaps
    task automatic send_cell(grt_in_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_cell(w);
    endtask

    task automatic stop_sending();
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // register write while idle; predictor updated at the same edge
    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == REG_THRESHOLD) sb.threshold = val;
        else sb.floor_q = val;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000 ^ ($urandom_range(3));
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            default: return $signed($urandom_range(20000)) - 10000 <<< $urandom_range(16);
        endcase
    endfunction

    function automatic grt_in_t rand_cell();
        grt_in_t w;
        logic [31:0] c;
        c = rand_val();
        w.center_value = c;
        // smooth neighbours most of the time so criteria land near the threshold
        if ($urandom_range(2) == 0)
        begin
            w.x_minus = rand_val(); w.x_plus = rand_val();
            w.y_minus = rand_val(); w.y_plus = rand_val();
            w.z_minus = rand_val(); w.z_plus = rand_val();
        end
        else
        begin
            w.x_minus = c + $signed($urandom_range(4000)) - 2000;
            w.x_plus  = c + $signed($urandom_range(4000)) - 2000;
            w.y_minus = c + $signed($urandom_range(400)) - 200;
            w.y_plus  = c + $signed($urandom_range(400)) - 200;
            w.z_minus = c + $signed($urandom_range(40000)) - 20000;
            w.z_plus  = c + $signed($urandom_range(40000)) - 20000;
        end
        w.already_tagged = ($urandom_range(9) == 0);
        w.covered = ($urandom_range(9) == 0);
        return w;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_cell(rand_cell());
        stop_sending();
    endtask

    task automatic directed_cells();
        grt_in_t w;
        logic [31:0] ext [4];
        ext[0] = 32'h8000_0000; ext[1] = 32'h7FFF_FFFF; ext[2] = 0; ext[3] = 32'hFFFF_FFFF;
        // field extremes in every slot
        for (int i = 0; i < 4; i++)
        begin
            w = '0;
            w.center_value = ext[i]; w.x_minus = ext[(i+1)%4]; w.x_plus = ext[(i+2)%4];
            w.y_minus = ext[(i+3)%4]; w.y_plus = ext[i]; w.z_minus = ext[(i+1)%4];
            w.z_plus = ext[(i+3)%4];
            send_cell(w);
        end
        // all zero: zero denominator with zero numerator
        w = '0; send_cell(w);
        // nonzero a on the x axis; b = 100*(|d|+|d|) + sum stays nonzero on that axis
        w = '0; w.center_value = 0; w.x_minus = -200; w.x_plus = 0;
        send_cell(w);
        // spike: large center over zero neighbours, ratio just under 1.0
        w = '0; w.center_value = 32'h7FFF_FFFF; send_cell(w);
        // skipped cells
        w = '0; w.x_plus = 32'h0001_0000; w.covered = 1; send_cell(w);
        w.already_tagged = 1; send_cell(w);
        w.covered = 0; send_cell(w);
        // linear profile: a = 0
        w = '0; w.center_value = 32'h0002_0000; w.x_minus = 32'h0001_0000;
        w.x_plus = 32'h0003_0000; send_cell(w);
        stop_sending();
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        directed_cells();
        wait_drained();

        // phase: both registers changed, no idling
        write_reg(REG_THRESHOLD, 32'h0000_8000);
        write_reg(REG_FLOOR, 32'h0000_0100);
        run_random(300);

        // receiver held off long while sender keeps offering
        fork
            begin
                sink_hold = 1;
                repeat (200) @(posedge clk);
                sink_hold = 0;
            end
            run_random(120);
        join
        wait_drained();

        // zero threshold, extreme floor
        write_reg(REG_THRESHOLD, 32'h0000_0000);
        write_reg(REG_FLOOR, 32'h7FFF_FFFF);
        src_idle_pct = 59;
        run_random(300);
        wait_drained();

        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(REG_FLOOR, 32'h8000_0000);
        src_idle_pct = 0; sink_stall_pct = 59;
        run_random(300);
        wait_drained();

        write_reg(REG_THRESHOLD, $urandom_range(32'h0004_0000));
        write_reg(REG_FLOOR, $urandom_range(32'h0000_2000));
        src_idle_pct = 23; sink_stall_pct = 23;
        run_random(350);
        wait_drained();

        write_reg(REG_THRESHOLD, THRESHOLD_RST);
        write_reg(REG_FLOOR, FLOOR_RST);
        src_idle_pct = 0; sink_stall_pct = 0;
        run_random(320);
        wait_drained();

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
